/* hw/rtl/hssc_pkg.sv */
// Package for the heater schedule safety controller.
// Holds command codes, register indexes, constants and the structs shared
// between the top level and the step engine. No dependencies.
package hssc_pkg;

   localparam int MAX_STEPS   = 4;
   localparam int NUM_WORDS   = 4;
   localparam int FAULT_LIMIT = 10;

   localparam int DUR_W  = 32;
   localparam int WORD_W = 34;
   localparam int STEP_W = 3;
   localparam int FC_W   = 4;
   localparam int TEMP_W = 16;

   typedef enum logic [1:0] {
      FUNC_TICK     = 2'd0,
      FUNC_SET_MODE = 2'd1,
      FUNC_START    = 2'd2,
      FUNC_STOP     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_WARM = 2'd1,
      MODE_LOW  = 2'd2,
      MODE_HIGH = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ALERT_NONE   = 2'd0,
      ALERT_TEMP   = 2'd1,
      ALERT_SENSOR = 2'd2
   } alert_type;

   localparam logic [2:0] REG_LENGTH = 3'd0;
   localparam logic [2:0] REG_REPEAT = 3'd1;
   localparam logic [2:0] REG_WORD_0 = 3'd2;
   localparam logic [2:0] REG_WORD_1 = 3'd3;
   localparam logic [2:0] REG_WORD_2 = 3'd4;
   localparam logic [2:0] REG_WORD_3 = 3'd5;
   localparam logic [2:0] REG_LIMIT  = 3'd6;

   localparam logic signed [TEMP_W-1:0] LIMIT_RESET = 16'sd4800;

   typedef struct packed {
      logic [STEP_W-1:0]                length;
      logic                             repeat_en;
      logic [NUM_WORDS-1:0][WORD_W-1:0] word;
      logic signed [TEMP_W-1:0]         limit;
   } cfg_type;

   typedef struct packed {
      func_type                 func;
      logic [1:0]               new_mode;
      logic signed [TEMP_W-1:0] temperature;
      logic                     sensor_fault;
   } item_type;

   typedef struct packed {
      logic [1:0]        heat_mode;
      logic              main_on;
      logic              aux_on;
      logic              program_active;
      logic [STEP_W-1:0] program_step;
      logic [DUR_W-1:0]  step_remaining;
      logic [1:0]        alert;
   } rsp_type;

endpackage

/* hw/rtl/heater_schedule_safety_controller_top.sv */
// Top level of the heater schedule safety controller.
// Holds the configuration registers, input register and result register;
// depends on hssc_pkg and hssc_engine.

// Each accepted item (tick, set mode, start, stop) yields exactly one result.
// An item is held in the input register, where the step engine updates the
// controller state, and then moves to the result register, from which the
// result is presented; a new item is taken every cycle while the result side
// keeps up. Configuration registers are written through the csr port and
// should be changed only while no item is in flight.
module heater_schedule_safety_controller_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_new_mode,
   input  logic signed [15:0] req_temperature,
   input  logic        req_sensor_fault,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_heat_mode,
   output logic        rsp_main_on,
   output logic        rsp_aux_on,
   output logic        rsp_program_active,
   output logic [2:0]  rsp_program_step,
   output logic [31:0] rsp_step_remaining,
   output logic [1:0]  rsp_alert,

   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [33:0] csr_data
);

   hssc_pkg::cfg_type  cfg_ff;
   hssc_pkg::item_type item_ff;
   logic               item_valid_ff;
   hssc_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff;
   logic               out_free;
   logic               take;
   logic               load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign take      = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign load      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.length    <= '0;
         cfg_ff.repeat_en <= 1'b0;
         cfg_ff.word      <= '0;
         cfg_ff.limit     <= hssc_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            hssc_pkg::REG_LENGTH: cfg_ff.length    <= csr_data[2:0];
            hssc_pkg::REG_REPEAT: cfg_ff.repeat_en <= csr_data[0];
            hssc_pkg::REG_WORD_0: cfg_ff.word[0]   <= csr_data;
            hssc_pkg::REG_WORD_1: cfg_ff.word[1]   <= csr_data;
            hssc_pkg::REG_WORD_2: cfg_ff.word[2]   <= csr_data;
            hssc_pkg::REG_WORD_3: cfg_ff.word[3]   <= csr_data;
            hssc_pkg::REG_LIMIT:  cfg_ff.limit     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (load) begin
         item_valid_ff <= 1'b1;
      end else if (take) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.func         <= hssc_pkg::func_type'(req_func);
         item_ff.new_mode     <= req_new_mode;
         item_ff.temperature  <= req_temperature;
         item_ff.sensor_fault <= req_sensor_fault;
      end
   end

   hssc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (item_ff),
      .cfg   (cfg_ff),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_heat_mode      = rsp_ff.heat_mode;
   assign rsp_main_on        = rsp_ff.main_on;
   assign rsp_aux_on         = rsp_ff.aux_on;
   assign rsp_program_active = rsp_ff.program_active;
   assign rsp_program_step   = rsp_ff.program_step;
   assign rsp_step_remaining = rsp_ff.step_remaining;
   assign rsp_alert          = rsp_ff.alert;

endmodule

/* hw/rtl/hssc_engine.sv */
// Step engine: controller state registers and the per-item update logic.
// Depends on hssc_pkg.
module hssc_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  hssc_pkg::item_type item,
   input  hssc_pkg::cfg_type cfg,
   output hssc_pkg::rsp_type rsp
);

   logic [1:0]                   mode_ff, mode_in;
   logic                         run_ff, run_in;
   logic [hssc_pkg::STEP_W-1:0]  idx_ff, idx_in;
   logic [hssc_pkg::DUR_W-1:0]   el_ff, el_in;
   logic [hssc_pkg::FC_W-1:0]    fc_ff, fc_in;

   function automatic logic [hssc_pkg::WORD_W-1:0] word_at(
      input hssc_pkg::cfg_type c,
      input logic [hssc_pkg::STEP_W-1:0] idx
   );
      logic [hssc_pkg::WORD_W-1:0] w;
      w = '0;
      if (!idx[2]) begin
         w = c.word[idx[1:0]];
      end
      return w;
   endfunction

   logic [hssc_pkg::STEP_W-1:0] len_eff;
   logic [hssc_pkg::WORD_W-1:0] cur_word, word0, new_word;
   logic [hssc_pkg::DUR_W-1:0]  cur_dur, new_dur, el_inc;
   logic [hssc_pkg::STEP_W:0]   next_idx;
   logic [hssc_pkg::FC_W-1:0]   fc_inc;
   logic [1:0]                  alert;
   logic [1:0]                  m;

   always_comb begin
      len_eff = ({1'b0, cfg.length} > (hssc_pkg::STEP_W+1)'(hssc_pkg::MAX_STEPS))
              ? hssc_pkg::STEP_W'(hssc_pkg::MAX_STEPS) : cfg.length;
      cur_word = word_at(cfg, idx_ff);
      word0    = word_at(cfg, '0);
      cur_dur  = cur_word[hssc_pkg::DUR_W-1:0];
      el_inc   = el_ff + 1'b1;
      next_idx = {1'b0, idx_ff} + 1'b1;
      fc_inc   = fc_ff + 1'b1;
   end

   always_comb begin
      mode_in = mode_ff;
      run_in  = run_ff;
      idx_in  = idx_ff;
      el_in   = el_ff;
      fc_in   = fc_ff;
      alert   = hssc_pkg::ALERT_NONE;
      case (item.func)
         hssc_pkg::FUNC_TICK: begin
            if (mode_in != hssc_pkg::MODE_OFF && item.temperature > cfg.limit) begin
               mode_in = hssc_pkg::MODE_OFF;
               run_in  = 1'b0;
               alert   = hssc_pkg::ALERT_TEMP;
            end
            if (mode_in != hssc_pkg::MODE_OFF && item.sensor_fault) begin
               if (fc_inc > hssc_pkg::FC_W'(hssc_pkg::FAULT_LIMIT)) begin
                  mode_in = hssc_pkg::MODE_OFF;
                  run_in  = 1'b0;
                  fc_in   = '0;
                  alert   = hssc_pkg::ALERT_SENSOR;
               end else begin
                  fc_in = fc_inc;
               end
            end else begin
               fc_in = '0;
            end
            if (run_in) begin
               el_in = el_inc;
               if (cur_dur != '0 && el_inc >= cur_dur) begin
                  el_in = '0;
                  if (next_idx >= {1'b0, len_eff}) begin
                     if (cfg.repeat_en) begin
                        idx_in  = '0;
                        mode_in = word0[hssc_pkg::WORD_W-1 -: 2];
                     end else begin
                        idx_in = next_idx[hssc_pkg::STEP_W-1:0];
                        run_in = 1'b0;
                     end
                  end else begin
                     idx_in  = next_idx[hssc_pkg::STEP_W-1:0];
                     mode_in = word_at(cfg, next_idx[hssc_pkg::STEP_W-1:0])
                               [hssc_pkg::WORD_W-1 -: 2];
                  end
               end
            end
         end
         hssc_pkg::FUNC_SET_MODE: begin
            mode_in = item.new_mode;
         end
         hssc_pkg::FUNC_START: begin
            if (len_eff != '0) begin
               run_in  = 1'b1;
               idx_in  = '0;
               el_in   = '0;
               mode_in = word0[hssc_pkg::WORD_W-1 -: 2];
            end
         end
         default: begin
            run_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      new_word = word_at(cfg, idx_in);
      new_dur  = new_word[hssc_pkg::DUR_W-1:0];
      m        = mode_in;
      rsp.heat_mode      = m;
      rsp.main_on        = (m == hssc_pkg::MODE_LOW)  || (m == hssc_pkg::MODE_HIGH);
      rsp.aux_on         = (m == hssc_pkg::MODE_WARM) || (m == hssc_pkg::MODE_HIGH);
      rsp.program_active = run_in;
      rsp.program_step   = idx_in;
      rsp.step_remaining = (run_in && new_dur != '0 && el_in < new_dur)
                         ? new_dur - el_in : '0;
      rsp.alert          = alert;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hssc_pkg::MODE_OFF;
         run_ff  <= 1'b0;
         idx_ff  <= '0;
         el_ff   <= '0;
         fc_ff   <= '0;
      end else if (take) begin
         mode_ff <= mode_in;
         run_ff  <= run_in;
         idx_ff  <= idx_in;
         el_ff   <= el_in;
         fc_ff   <= fc_in;
      end
   end

endmodule

/* tb/hssc_status_checker.sv */
// Status checker for the heater schedule safety controller.
// Watches the req, rsp and csr ports, predicts each status item and compares;
// depends on hssc_pkg.
`timescale 1ns / 1ps

module hssc_status_checker
   import hssc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [1:0]         req_new_mode,
   input  logic signed [15:0] req_temperature,
   input  logic               req_sensor_fault,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_heat_mode,
   input  logic               rsp_main_on,
   input  logic               rsp_aux_on,
   input  logic               rsp_program_active,
   input  logic [2:0]         rsp_program_step,
   input  logic [31:0]        rsp_step_remaining,
   input  logic [1:0]         rsp_alert,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [33:0]        csr_data,
   output int                 mismatches,
   output int                 pending
);

   // configuration copy
   logic [STEP_W-1:0]        len_cfg;
   logic                     rep_cfg;
   logic [WORD_W-1:0]        words [NUM_WORDS];
   logic signed [TEMP_W-1:0] limit_cfg;

   // controller state
   mode_type          mode_q;
   logic              run_q;
   logic [STEP_W-1:0] step_q;
   logic [DUR_W-1:0]  elapsed_q;
   logic [FC_W-1:0]   faults_q;

   rsp_type status_q [$];

   initial begin
      mismatches = 0;
      pending = 0;
   end

   task automatic report_fault(string msg);
      $display("%0t status check: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_fault($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   task automatic clear_model();
      len_cfg = '0;
      rep_cfg = 1'b0;
      for (int i = 0; i < NUM_WORDS; i++) words[i] = '0;
      limit_cfg = LIMIT_RESET;
      mode_q = MODE_OFF;
      run_q = 1'b0;
      step_q = '0;
      elapsed_q = '0;
      faults_q = '0;
   endtask

   task automatic apply_write(logic [2:0] idx, logic [33:0] data);
      case (idx) inside
         REG_LENGTH: len_cfg = data[STEP_W-1:0];
         REG_REPEAT: rep_cfg = data[0];
         REG_WORD_0, REG_WORD_1, REG_WORD_2, REG_WORD_3:
            words[2'(idx - REG_WORD_0)] = data;
         REG_LIMIT: limit_cfg = data[TEMP_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [WORD_W-1:0] step_word(logic [STEP_W-1:0] idx);
      if (idx < NUM_WORDS) return words[idx[1:0]];
      return '0;
   endfunction

   function automatic int step_count();
      if (len_cfg > MAX_STEPS) return MAX_STEPS;
      return int'(len_cfg);
   endfunction

   function automatic rsp_type next_status(func_type f, logic [1:0] new_mode,
                                           logic signed [TEMP_W-1:0] temp, logic fault);
      alert_type         al;
      logic [DUR_W-1:0]  dur;
      logic [WORD_W-1:0] w;
      int                nxt;
      rsp_type           r;
      al = ALERT_NONE;
      case (f)
         FUNC_TICK: begin
            if (mode_q != MODE_OFF && temp > limit_cfg) begin
               mode_q = MODE_OFF;
               run_q = 1'b0;
               al = ALERT_TEMP;
            end
            if (mode_q != MODE_OFF && fault) begin
               faults_q = faults_q + 1'b1;
               if (faults_q > FAULT_LIMIT) begin
                  mode_q = MODE_OFF;
                  run_q = 1'b0;
                  faults_q = '0;
                  al = ALERT_SENSOR;
               end
            end else begin
               faults_q = '0;
            end
            if (run_q) begin
               elapsed_q = elapsed_q + 1'b1;
               w = step_word(step_q);
               dur = w[DUR_W-1:0];
               if (dur != 0 && elapsed_q >= dur) begin
                  nxt = int'(step_q) + 1;
                  elapsed_q = '0;
                  if (nxt >= step_count()) begin
                     if (rep_cfg) begin
                        step_q = '0;
                        w = step_word('0);
                        mode_q = mode_type'(w[WORD_W-1:DUR_W]);
                     end else begin
                        step_q = nxt[STEP_W-1:0];
                        run_q = 1'b0;
                     end
                  end else begin
                     step_q = nxt[STEP_W-1:0];
                     w = step_word(step_q);
                     mode_q = mode_type'(w[WORD_W-1:DUR_W]);
                  end
               end
            end
         end
         FUNC_SET_MODE: mode_q = mode_type'(new_mode);
         FUNC_START: begin
            if (step_count() != 0) begin
               run_q = 1'b1;
               step_q = '0;
               elapsed_q = '0;
               w = step_word('0);
               mode_q = mode_type'(w[WORD_W-1:DUR_W]);
            end
         end
         default: run_q = 1'b0;
      endcase
      r.step_remaining = '0;
      if (run_q) begin
         w = step_word(step_q);
         dur = w[DUR_W-1:0];
         if (dur != 0 && elapsed_q < dur) r.step_remaining = dur - elapsed_q;
      end
      r.heat_mode = mode_q;
      r.main_on = (mode_q == MODE_LOW || mode_q == MODE_HIGH);
      r.aux_on = (mode_q == MODE_WARM || mode_q == MODE_HIGH);
      r.program_active = run_q;
      r.program_step = step_q;
      r.alert = al;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_model();
         status_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               report_fault("status item with none expected");
            end else begin
               want = status_q.pop_front();
               check_field("heat_mode", rsp_heat_mode, want.heat_mode);
               check_field("main_on", rsp_main_on, want.main_on);
               check_field("aux_on", rsp_aux_on, want.aux_on);
               check_field("program_active", rsp_program_active, want.program_active);
               check_field("program_step", rsp_program_step, want.program_step);
               check_field("step_remaining", rsp_step_remaining, want.step_remaining);
               check_field("alert", rsp_alert, want.alert);
            end
         end
         if (req_valid && !req_stall) begin
            status_q.push_back(next_status(func_type'(req_func), req_new_mode,
                                           req_temperature, req_sensor_fault));
         end
         if (csr_write) apply_write(csr_index, csr_data);
      end
      pending = status_q.size();
   end

endmodule

/* tb/tb_heater_schedule_safety_controller_top.sv */
// Testbench top for the heater schedule safety controller.
// Drives commands, ticks and register writes with random idling and stalls;
// depends on hssc_pkg, the controller RTL and hssc_status_checker.
`timescale 1ns / 1ps

module tb_heater_schedule_safety_controller_top;
   import hssc_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_func;
   logic [1:0]         req_new_mode;
   logic signed [15:0] req_temperature;
   logic               req_sensor_fault;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_heat_mode;
   logic               rsp_main_on;
   logic               rsp_aux_on;
   logic               rsp_program_active;
   logic [2:0]         rsp_program_step;
   logic [31:0]        rsp_step_remaining;
   logic [1:0]         rsp_alert;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [33:0]        csr_data;
   int                 mismatches;
   int                 pending;

   logic               sender_idle;
   logic               receiver_idle;
   logic               hold_request;
   logic signed [15:0] cur_limit;
   int                 hot_pct;
   int                 fault_pct;

   heater_schedule_safety_controller_top dut (.*);

   hssc_status_checker status_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("heater_schedule_safety_controller_top: mismatch");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (60) @(negedge clock);
            hold_request = 1'b0;
         end
         gap = receiver_idle ? $urandom_range(0, 11) : 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic set_reg(logic [2:0] idx, logic [33:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
      if (idx == REG_LIMIT) cur_limit = data[15:0];
   endtask

   task automatic send(func_type f, logic [1:0] m, logic signed [15:0] t, logic sf);
      int gap;
      gap = sender_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func <= f;
      req_new_mode <= m;
      req_temperature <= t;
      req_sensor_fault <= sf;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle(int cycles);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic [33:0] random_word();
      int         pick;
      logic [31:0] dur;
      pick = $urandom_range(0, 9);
      if (pick < 7) dur = $urandom_range(1, 4);
      else if (pick == 7) dur = '0;
      else if (pick == 8) dur = '1;
      else dur = $urandom;
      return {2'($urandom_range(0, 3)), dur};
   endfunction

   task automatic random_item();
      func_type f;
      int       pick;
      int       t;
      pick = $urandom_range(0, 99);
      if (pick < 65) f = FUNC_TICK;
      else if (pick < 77) f = FUNC_SET_MODE;
      else if (pick < 90) f = FUNC_START;
      else f = FUNC_STOP;
      pick = $urandom_range(0, 99);
      if (pick < 8) t = int'($urandom_range(0, 65535)) - 32768;
      else if (pick < 8 + hot_pct) t = int'(cur_limit) + int'($urandom_range(1, 40));
      else t = int'(cur_limit) - int'($urandom_range(0, 300));
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      send(f, 2'($urandom_range(0, 3)), 16'(t), $urandom_range(0, 99) < fault_pct);
   endtask

   task automatic configure_phase(int phase);
      int lim;
      case (phase)
         0: begin
            set_reg(REG_LENGTH, 34'd7);
            set_reg(REG_REPEAT, 34'd1);
            set_reg(REG_WORD_0, {MODE_LOW, 32'd2});
            set_reg(REG_WORD_1, {MODE_HIGH, 32'd1});
            set_reg(REG_WORD_2, {MODE_WARM, 32'd3});
            set_reg(REG_WORD_3, {MODE_HIGH, 32'hFFFF_FFFF});
            set_reg(REG_LIMIT, 34'h0_7FFF);
         end
         1: begin
            set_reg(REG_LENGTH, 34'd4);
            set_reg(REG_REPEAT, 34'd0);
            set_reg(REG_WORD_3, {MODE_WARM, 32'd1});
            set_reg(REG_LIMIT, 34'h0_8000);
         end
         2: begin
            set_reg(REG_LENGTH, 34'd0);
            set_reg(REG_UNUSED, {2'($urandom_range(0, 3)), 32'($urandom)});
            set_reg(REG_LIMIT, 34'd4800);
         end
         default: begin
            if ($urandom_range(0, 1)) set_reg(REG_LENGTH, 34'($urandom_range(0, 7)));
            if ($urandom_range(0, 1)) set_reg(REG_REPEAT, 34'($urandom_range(0, 1)));
            if ($urandom_range(0, 1)) set_reg(REG_WORD_0, random_word());
            if ($urandom_range(0, 1)) set_reg(REG_WORD_1, random_word());
            if ($urandom_range(0, 1)) set_reg(REG_WORD_2, random_word());
            if ($urandom_range(0, 1)) set_reg(REG_WORD_3, random_word());
            if ($urandom_range(0, 3) == 0) set_reg(REG_UNUSED, 34'($urandom));
            if ($urandom_range(0, 1)) begin
               lim = $urandom_range(0, 9);
               if (lim == 0) set_reg(REG_LIMIT, 34'($urandom_range(0, 65535)));
               else if (lim == 1) set_reg(REG_LIMIT, 34'h0_7FFF);
               else set_reg(REG_LIMIT, 34'($urandom_range(1000, 6000)));
            end
         end
      endcase
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_TICK;
      req_new_mode = MODE_OFF;
      req_temperature = '0;
      req_sensor_fault = 1'b0;
      csr_write = 1'b0;
      csr_index = REG_LENGTH;
      csr_data = '0;
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      hold_request = 1'b0;
      cur_limit = LIMIT_RESET;
      hot_pct = 2;
      fault_pct = 3;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // safety cut-offs and manual modes with reset configuration
      send(FUNC_TICK, MODE_OFF, 16'sd0, 1'b0);
      send(FUNC_START, MODE_OFF, 16'sd0, 1'b0);
      send(FUNC_SET_MODE, MODE_HIGH, 16'sd0, 1'b0);
      send(FUNC_TICK, MODE_OFF, 16'sd4800, 1'b0);
      send(FUNC_TICK, MODE_OFF, 16'sh7FFF, 1'b0);
      send(FUNC_SET_MODE, MODE_WARM, 16'sd0, 1'b0);
      repeat (11) send(FUNC_TICK, MODE_OFF, 16'sd100, 1'b1);
      send(FUNC_TICK, MODE_OFF, 16'sh8000, 1'b1);
      send(FUNC_STOP, MODE_OFF, 16'sd0, 1'b0);
      send(FUNC_SET_MODE, MODE_LOW, 16'sd0, 1'b0);
      send(FUNC_SET_MODE, MODE_OFF, 16'sd0, 1'b0);

      // a short program: timed steps then an indefinite one
      settle(4);
      set_reg(REG_LENGTH, 34'd3);
      set_reg(REG_WORD_0, {MODE_LOW, 32'd2});
      set_reg(REG_WORD_1, {MODE_HIGH, 32'd1});
      set_reg(REG_WORD_2, {MODE_WARM, 32'd0});
      send(FUNC_START, MODE_OFF, 16'sd0, 1'b0);
      send(FUNC_TICK, MODE_OFF, 16'sd10, 1'b1);
      repeat (3) send(FUNC_TICK, MODE_OFF, 16'sd10, 1'b0);
      send(FUNC_STOP, MODE_OFF, 16'sd0, 1'b0);

      for (int phase = 0; phase < 15; phase++) begin
         settle(4);
         configure_phase(phase);
         sender_idle = ($urandom_range(0, 2) != 0);
         receiver_idle = ($urandom_range(0, 2) != 0);
         hot_pct = ($urandom_range(0, 3) == 0) ? 15 : 2;
         fault_pct = ($urandom_range(0, 2) == 0) ? 92 : 3;
         if (phase == 4) begin
            sender_idle = 1'b0;
            receiver_idle = 1'b0;
            hold_request = 1'b1;
         end
         repeat (40) random_item();
      end

      settle(10);
      if (mismatches == 0) begin
         $display("heater_schedule_safety_controller_top: match");
      end else begin
         $display("heater_schedule_safety_controller_top: mismatch");
      end
      $finish;
   end

endmodule
